### hdl/dsp_pkg.sv
package dsp_pkg;

  // Fixed field widths of the request and result channels
  localparam int MODE_BITS   = 2;
  localparam int NODE_BITS   = 6;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_BITS  = 7;
  localparam int DIST_BITS   = 22;

  // Distances saturate at the largest path_length
  localparam logic [DIST_BITS-1:0]  DIST_LIMIT       = '1;
  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_FETCH,
    ST_DONE
  } state_t;

  // One word of node work memory
  typedef struct packed {
    logic                 done;
    logic                 reached;
    logic [DIST_BITS-1:0] distance;
  } node_word_t;

  // Status from the shared add/compare unit
  typedef struct packed {
    logic                 less;
    logic [DIST_BITS-1:0] sum;
  } alu_res_t;

endpackage

### hdl/dsp_if.sv
interface dsp_in_if;
  logic                            valid;
  logic                            ready;
  logic [dsp_pkg::MODE_BITS-1:0]   mode;
  logic [dsp_pkg::NODE_BITS-1:0]   node_a;
  logic [dsp_pkg::NODE_BITS-1:0]   node_b;
  logic [dsp_pkg::WEIGHT_BITS-1:0] edge_weight;

  modport source (output valid, output mode, output node_a, output node_b,
                  output edge_weight, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b,
                  input edge_weight, output ready);
endinterface

interface dsp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          path_found;
  logic [dsp_pkg::DIST_BITS-1:0] path_length;

  modport source (output valid, output path_found, output path_length, input ready);
  modport sink   (input valid, input path_found, input path_length, output ready);
endinterface

### hdl/dsp_ram.sv
module dsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dsp_alu.sv
// Shared saturating add and less-than compare.
module dsp_alu #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic [dsp_pkg::DIST_BITS-1:0] base,
  input  logic [WEIGHT_BITS-1:0]        addend,
  input  logic [dsp_pkg::DIST_BITS-1:0] limit,
  output dsp_pkg::alu_res_t             res
);

  localparam int SW = ((WEIGHT_BITS > dsp_pkg::DIST_BITS) ?
                       WEIGHT_BITS : dsp_pkg::DIST_BITS) + 1;

  logic [SW-1:0]                 sum_wide;
  logic [dsp_pkg::DIST_BITS-1:0] sum_sat;

  assign sum_wide = SW'(base) + SW'(addend);
  assign sum_sat  = (sum_wide > SW'(dsp_pkg::DIST_LIMIT)) ?
                    dsp_pkg::DIST_LIMIT : sum_wide[dsp_pkg::DIST_BITS-1:0];

  assign res.sum  = sum_sat;
  assign res.less = (sum_sat < limit);

endmodule

### hdl/dense_shortest_path_unit.sv
// Shortest-path engine over an undirected weighted graph of up to MAX_NODE_COUNT
// nodes, held as an adjacency matrix in RAM (weight 0 = no edge). A clear
// request (mode 0) and reset both start a clearing pass that writes one matrix
// entry per cycle over the whole matrix, with request.ready low. An edge
// request (mode 1) writes both mirrored entries, first in ST_IDLE and then in
// ST_EDGE2. A query (mode 2) runs Dijkstra from node_a over the first
// n = node_count nodes (at most MAX_NODE_COUNT) with one shared add/compare
// unit: it takes the request, initializes the node memory, then runs up to
// n-1 rounds of a minimum scan and a relaxation pass, and reads out the
// destination. A query with an endpoint at or beyond n goes straight to the
// readout and reports no path. The query yields one result; mode 1, mode 0
// and the unused mode 3 yield none. One request is in work at a time; a
// finished result waits in an output register and the next request is taken
// meanwhile. The user must write node_count through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this.
module dense_shortest_path_unit #(
  parameter int MAX_NODE_COUNT = 64,
  parameter int WEIGHT_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dsp_pkg::COUNT_BITS-1:0]   cfg_wr_data,
  dsp_in_if.sink                           request,
  dsp_out_if.source                        result
);

  localparam int NB    = $clog2(MAX_NODE_COUNT);       // node index bits
  localparam int CB    = $clog2(MAX_NODE_COUNT + 1);   // node count bits
  localparam int DEPTH = MAX_NODE_COUNT * MAX_NODE_COUNT;
  localparam int AB    = $clog2(DEPTH);
  localparam int DB    = dsp_pkg::DIST_BITS;
  localparam int NWB   = $bits(dsp_pkg::node_word_t);

  function automatic logic [AB-1:0] adj_addr(input logic [NB-1:0] row,
                                             input logic [NB-1:0] col);
    return AB'(32'(row) * MAX_NODE_COUNT + 32'(col));
  endfunction

  dsp_pkg::state_t state, state_next;

  // config
  logic [dsp_pkg::COUNT_BITS-1:0] node_count;
  logic [CB-1:0]                  n_eff;

  // control
  logic [AB-1:0] clr_addr;
  logic [CB-1:0] idx;
  logic [CB-1:0] rounds;
  logic          rv;           // read data valid for node ri
  logic [NB-1:0] ri;
  logic          issue;
  logic          accept;

  // query context
  logic [CB-1:0]          n_q;
  logic [NB-1:0]          src_q, dst_q;
  logic                   miss;
  logic [NB-1:0]          u_q;
  logic [DB-1:0]          best_d;
  logic                   best_ok;
  logic                   take_best;
  logic                   relax_hit;

  // edge write context
  logic [NB-1:0]          a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [WEIGHT_BITS-1:0] w_in;
  logic                   a_ok, b_ok;

  // memories
  logic                   adj_we;
  logic [AB-1:0]          adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_rd;
  logic                   node_we;
  logic [NB-1:0]          node_waddr, node_raddr;
  dsp_pkg::node_word_t    node_wdata, node_rd;
  logic [NWB-1:0]         node_rd_raw;

  // shared add/compare
  logic [DB-1:0]          alu_base, alu_limit;
  logic [WEIGHT_BITS-1:0] alu_add;
  dsp_pkg::alu_res_t      alu_res;

  // output register
  logic                   out_valid;
  logic                   out_found;
  logic [DB-1:0]          out_len;
  logic                   load_out;
  logic                   res_found;

  dsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rd)
  );

  dsp_ram #(.WIDTH(NWB), .DEPTH(MAX_NODE_COUNT)) u_node (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rd_raw)
  );

  assign node_rd = dsp_pkg::node_word_t'(node_rd_raw);

  dsp_alu #(.WEIGHT_BITS(WEIGHT_BITS)) u_alu (
    .base   (alu_base),
    .addend (alu_add),
    .limit  (alu_limit),
    .res    (alu_res)
  );

  // node_count above the store size acts as the store size
  assign n_eff = (32'(node_count) > MAX_NODE_COUNT) ? CB'(MAX_NODE_COUNT) : CB'(node_count);
  assign w_in  = WEIGHT_BITS'(request.edge_weight);
  assign a_ok  = (32'(request.node_a) < MAX_NODE_COUNT);
  assign b_ok  = (32'(request.node_b) < MAX_NODE_COUNT);

  assign request.ready = (state == dsp_pkg::ST_IDLE);
  assign accept        = request.valid && request.ready;

  assign res_found = !miss && node_rd.reached;

  assign result.valid       = out_valid;
  assign result.path_found  = out_found;
  assign result.path_length = out_len;

  // next state and datapath strobes
  always_comb begin
    state_next = state;
    adj_we     = 1'b0;
    adj_waddr  = clr_addr;
    adj_wdata  = '0;
    adj_raddr  = adj_addr(u_q, NB'(idx));
    node_we    = 1'b0;
    node_waddr = ri;
    node_wdata = '0;
    node_raddr = dst_q;
    issue      = 1'b0;
    take_best  = 1'b0;
    relax_hit  = 1'b0;
    load_out   = 1'b0;
    alu_base   = best_d;
    alu_add    = '0;
    alu_limit  = node_rd.distance;

    case (state)
      dsp_pkg::ST_CLEAR: begin
        adj_we = 1'b1;
        if (clr_addr == AB'(DEPTH - 1)) begin
          state_next = dsp_pkg::ST_IDLE;
        end
      end

      dsp_pkg::ST_IDLE: begin
        if (accept) begin
          case (request.mode)
            dsp_pkg::MODE_CLEAR: begin
              state_next = dsp_pkg::ST_CLEAR;
            end
            dsp_pkg::MODE_EDGE: begin
              // endpoints beyond the store are dropped
              if (a_ok && b_ok) begin
                adj_we     = 1'b1;
                adj_waddr  = adj_addr(NB'(request.node_a), NB'(request.node_b));
                adj_wdata  = w_in;
                state_next = dsp_pkg::ST_EDGE2;
              end
            end
            dsp_pkg::MODE_QUERY: begin
              if ((32'(request.node_a) >= 32'(n_eff)) ||
                  (32'(request.node_b) >= 32'(n_eff))) begin
                state_next = dsp_pkg::ST_DONE;
              end else begin
                state_next = dsp_pkg::ST_INIT;
              end
            end
            default: begin
              state_next = dsp_pkg::ST_IDLE;
            end
          endcase
        end
      end

      dsp_pkg::ST_EDGE2: begin
        adj_we     = 1'b1;
        adj_waddr  = adj_addr(b_q, a_q);
        adj_wdata  = w_q;
        state_next = dsp_pkg::ST_IDLE;
      end

      dsp_pkg::ST_INIT: begin
        node_we            = 1'b1;
        node_waddr         = NB'(idx);
        node_wdata.reached = (NB'(idx) == src_q);
        if (idx == n_q - CB'(1)) begin
          state_next = (n_q > CB'(1)) ? dsp_pkg::ST_SCAN : dsp_pkg::ST_FETCH;
        end
      end

      dsp_pkg::ST_SCAN: begin
        issue      = (idx != n_q);
        node_raddr = NB'(idx);
        alu_base   = node_rd.distance;
        alu_limit  = best_d;
        take_best  = rv && !node_rd.done && node_rd.reached && (!best_ok || alu_res.less);
        if (!issue) begin
          state_next = dsp_pkg::ST_PICK;
        end
      end

      dsp_pkg::ST_PICK: begin
        if (best_ok) begin
          node_we             = 1'b1;
          node_waddr          = u_q;
          node_wdata.done     = 1'b1;
          node_wdata.reached  = 1'b1;
          node_wdata.distance = best_d;
          state_next          = dsp_pkg::ST_RELAX;
        end else begin
          // nothing left to reach
          state_next = dsp_pkg::ST_FETCH;
        end
      end

      dsp_pkg::ST_RELAX: begin
        issue      = (idx != n_q);
        node_raddr = NB'(idx);
        alu_add    = adj_rd;
        relax_hit  = rv && !node_rd.done && (adj_rd != '0) &&
                     (!node_rd.reached || alu_res.less);
        if (relax_hit) begin
          node_we             = 1'b1;
          node_wdata.reached  = 1'b1;
          node_wdata.distance = alu_res.sum;
        end
        if (!issue) begin
          state_next = ((CB + 1)'(rounds) + (CB + 1)'(2) < (CB + 1)'(n_q)) ?
                       dsp_pkg::ST_SCAN : dsp_pkg::ST_FETCH;
        end
      end

      dsp_pkg::ST_FETCH: begin
        state_next = dsp_pkg::ST_DONE;
      end

      dsp_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = dsp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dsp_pkg::NODE_COUNT_RESET;
      clr_addr   <= '0;
      rv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (state == dsp_pkg::ST_CLEAR) begin
        clr_addr <= (clr_addr == AB'(DEPTH - 1)) ? '0 : clr_addr + AB'(1);
      end
      rv <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query and edge context
  always_ff @(posedge clk) begin
    ri <= NB'(idx);
    case (state)
      dsp_pkg::ST_IDLE: begin
        a_q   <= NB'(request.node_a);
        b_q   <= NB'(request.node_b);
        w_q   <= w_in;
        src_q <= NB'(request.node_a);
        dst_q <= NB'(request.node_b);
        n_q   <= n_eff;
        miss  <= (32'(request.node_a) >= 32'(n_eff)) ||
                 (32'(request.node_b) >= 32'(n_eff));
        idx   <= '0;
      end
      dsp_pkg::ST_INIT: begin
        best_ok <= 1'b0;
        rounds  <= '0;
        idx     <= (idx == n_q - CB'(1)) ? '0 : idx + CB'(1);
      end
      dsp_pkg::ST_SCAN: begin
        if (issue) begin
          idx <= idx + CB'(1);
        end
        if (take_best) begin
          best_ok <= 1'b1;
          u_q     <= ri;
          best_d  <= node_rd.distance;
        end
      end
      dsp_pkg::ST_PICK: begin
        idx <= '0;
      end
      dsp_pkg::ST_RELAX: begin
        best_ok <= 1'b0;
        if (issue) begin
          idx <= idx + CB'(1);
        end else begin
          idx    <= '0;
          rounds <= rounds + CB'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= res_found;
      out_len   <= res_found ? node_rd.distance : '0;
    end
  end

  // a new result only comes out of the readout state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    load_out |-> state == dsp_pkg::ST_DONE && state_next == dsp_pkg::ST_IDLE)
    else $error("result loaded outside readout");

  // node memory is only written while a query is at work
  a_node_write_state: assert property (@(posedge clk) disable iff (rst)
    node_we |-> (state == dsp_pkg::ST_INIT || state == dsp_pkg::ST_PICK ||
                 state == dsp_pkg::ST_RELAX))
    else $error("node memory written outside a query");

  // the picked node lies inside the graph in use
  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == dsp_pkg::ST_PICK && best_ok) |-> (CB'(u_q) < n_q))
    else $error("picked node out of range");

  // reset always starts a clearing pass
  a_reset_clears: assert property (@(posedge clk)
    $fell(rst) |-> state == dsp_pkg::ST_CLEAR && clr_addr == '0)
    else $error("no clearing pass after reset");

  // matrix writes happen only while clearing, while idle or in ST_EDGE2, never in a query
  a_adj_write_state: assert property (@(posedge clk) disable iff (rst)
    adj_we |-> (state == dsp_pkg::ST_CLEAR || state == dsp_pkg::ST_IDLE ||
                state == dsp_pkg::ST_EDGE2))
    else $error("matrix written during a query");

endmodule

### dv/tb_dense_shortest_path_unit.sv
module tb_dense_shortest_path_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES        = 64;
  localparam int CLK_PERIOD   = 10;
  // Wait that covers a full matrix clear plus slack.
  localparam int SETTLE_CYCLES = NODES * NODES + 64;
  // Long result-side hold-off used to fill the block and back up requests.
  localparam int HOLD_CYCLES  = 400;
  // Cycle limit for the whole run, set well beyond the slowest legal run.
  localparam int CYCLE_LIMIT  = 2_000_000;

  // Mode 3 has no enum member; the block drops it without a result.
  localparam logic [dsp_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                          found;
    logic [dsp_pkg::DIST_BITS-1:0] length;
  } path_answer_t;

  localparam path_answer_t NO_PATH   = '0;
  localparam path_answer_t ZERO_HOPS = '{1'b1, 22'd0};

  typedef enum logic {ROW_REQUEST, ROW_NODE_COUNT} row_kind_t;

  // One line of the hand-written stimulus. "typed" rows carry an answer that
  // is obvious by inspection; the rest take theirs from the path solver.
  typedef struct {
    row_kind_t                       kind;
    logic [dsp_pkg::MODE_BITS-1:0]   mode;
    logic [dsp_pkg::NODE_BITS-1:0]   a;
    logic [dsp_pkg::NODE_BITS-1:0]   b;
    logic [dsp_pkg::WEIGHT_BITS-1:0] w;
    logic [dsp_pkg::COUNT_BITS-1:0]  count;
    bit                              typed;
    path_answer_t                    want;
  } plan_row_t;

  // One random phase: node count, an optional clear, a graph build, then queries.
  typedef struct {
    logic [dsp_pkg::COUNT_BITS-1:0] count;
    bit                             clear_first;
    int                             edges;
    int                             queries;
    bit                             burst;
    bit                             steady;
  } phase_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [dsp_pkg::COUNT_BITS-1:0] cfg_wr_data;

  dsp_in_if  req_if ();
  dsp_out_if res_if ();

  dense_shortest_path_unit #(
    .MAX_NODE_COUNT(NODES),
    .WEIGHT_BITS(dsp_pkg::WEIGHT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .request(req_if),
    .result(res_if)
  );

  // ---------------------------------------------------------------------------
  // Directed stimulus. Starts at the reset node count of 64 on an empty graph,
  // covers the widest weight, a self loop, edge removal, the unused mode, a
  // clear, endpoints beyond the node count, node counts of 0, 1 and 127.
  // ---------------------------------------------------------------------------
  plan_row_t directed_plan [29] = '{
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd63, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd5, 6'd5, 16'd0, 7'd0, 1'b1, ZERO_HOPS},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd0, 6'd63, 16'd65535, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd63, 16'd0, 7'd0, 1'b1, '{1'b1, 22'd65535}},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd63, 6'd63, 16'd1, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd63, 6'd0, 16'd0, 7'd0, 1'b1, '{1'b1, 22'd65535}},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd0, 6'd63, 16'd0, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd63, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd1, 6'd2, 16'd3, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd2, 6'd3, 16'd4, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd1, 6'd3, 16'd10, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd1, 6'd3, 16'd0, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, MODE_UNUSED, 6'd63, 6'd63, 16'd65535, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_CLEAR, 6'd0, 6'd0, 16'd0, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd1, 6'd3, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_NODE_COUNT, dsp_pkg::MODE_CLEAR, 6'd0, 6'd0, 16'd0, 7'd4, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd2, 6'd5, 16'd7, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd2, 6'd5, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd5, 6'd2, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd0, 6'd1, 16'd65535, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_EDGE, 6'd1, 6'd2, 16'd65535, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd2, 16'd0, 7'd0, 1'b0, NO_PATH},
    '{ROW_NODE_COUNT, dsp_pkg::MODE_CLEAR, 6'd0, 6'd0, 16'd0, 7'd0, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd0, 16'd0, 7'd0, 1'b1, NO_PATH},
    '{ROW_NODE_COUNT, dsp_pkg::MODE_CLEAR, 6'd0, 6'd0, 16'd0, 7'd1, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd0, 16'd0, 7'd0, 1'b1, ZERO_HOPS},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd0, 6'd1, 16'd0, 7'd0, 1'b1, NO_PATH},
    // 127 is above the matrix size and must behave like 64
    '{ROW_NODE_COUNT, dsp_pkg::MODE_CLEAR, 6'd0, 6'd0, 16'd0, 7'd127, 1'b0, NO_PATH},
    '{ROW_REQUEST, dsp_pkg::MODE_QUERY, 6'd2, 6'd5, 16'd0, 7'd0, 1'b0, NO_PATH}
  };

  // Random phases. Most node counts are small to keep queries short; 64 and
  // 127 get only a handful of queries since those queries run longest.
  // The burst phase pairs back-to-back queries with a long result hold-off.
  phase_t phase_plan [7] = '{
    '{7'd6,   1'b1, 6,  6, 1'b0, 1'b0},
    '{7'd3,   1'b0, 4,  8, 1'b1, 1'b1},
    '{7'd16,  1'b1, 10, 6, 1'b0, 1'b1},
    '{7'd64,  1'b0, 8,  3, 1'b0, 1'b0},
    '{7'd127, 1'b0, 3,  2, 1'b0, 1'b0},
    '{7'd2,   1'b0, 2,  4, 1'b0, 1'b0},
    '{7'd9,   1'b1, 5,  4, 1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Path solver: own copy of the weight matrix and node count.
  // ---------------------------------------------------------------------------
  logic [dsp_pkg::WEIGHT_BITS-1:0] graph_weight [NODES][NODES];
  logic [dsp_pkg::COUNT_BITS-1:0]  node_count_cfg;

  path_answer_t answers_due [$];

  int mismatch_count  = 0;
  int answers_checked = 0;
  int queries_sent    = 0;
  int edges_sent      = 0;
  int clears_sent     = 0;
  int unused_sent     = 0;
  int cycle_count     = 0;

  // Sender-to-sink controls, written with nonblocking assignments only.
  int hold_tickets = 0;
  int holds_served;
  int sink_count;
  bit steady = 1'b0;

  // Dijkstra over the first n nodes. Each round takes the lowest-index node
  // with the least distance among those reached and not yet settled, then
  // relaxes its unsettled neighbors. Sums saturate at DIST_LIMIT.
  function automatic path_answer_t shortest_distance(
      input logic [dsp_pkg::NODE_BITS-1:0] src,
      input logic [dsp_pkg::NODE_BITS-1:0] dst);
    logic [dsp_pkg::DIST_BITS-1:0] node_dist [NODES];
    bit                            settled [NODES];
    bit                            reached [NODES];
    logic [dsp_pkg::DIST_BITS:0]   cand;
    int unsigned                   n;
    int                            nearest;
    path_answer_t                  ans;
    ans = NO_PATH;
    n = (node_count_cfg > NODES) ? NODES : node_count_cfg;
    if (src >= n || dst >= n) return ans;
    for (int i = 0; i < NODES; i++) begin
      node_dist[i] = '0;
      settled[i]   = 1'b0;
      reached[i]   = 1'b0;
    end
    reached[src] = 1'b1;
    for (int unsigned rnd = 0; rnd + 1 < n; rnd++) begin
      nearest = -1;
      for (int i = 0; i < n; i++) begin
        if (!settled[i] && reached[i] &&
            (nearest < 0 || node_dist[i] < node_dist[nearest])) begin
          nearest = i;
        end
      end
      if (nearest < 0) break;
      settled[nearest] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (!settled[v] && graph_weight[nearest][v] != '0) begin
          cand = {1'b0, node_dist[nearest]} + graph_weight[nearest][v];
          if (cand > dsp_pkg::DIST_LIMIT) cand = dsp_pkg::DIST_LIMIT;
          if (!reached[v] || cand[dsp_pkg::DIST_BITS-1:0] < node_dist[v]) begin
            node_dist[v] = cand[dsp_pkg::DIST_BITS-1:0];
            reached[v]   = 1'b1;
          end
        end
      end
    end
    if (reached[dst]) ans = '{1'b1, node_dist[dst]};
    return ans;
  endfunction

  // Applies one accepted request to the graph copy; queries yield an answer.
  function automatic void apply_request(input logic [dsp_pkg::MODE_BITS-1:0] mode,
                                        input logic [dsp_pkg::NODE_BITS-1:0] a,
                                        input logic [dsp_pkg::NODE_BITS-1:0] b,
                                        input logic [dsp_pkg::WEIGHT_BITS-1:0] w,
                                        output bit yields,
                                        output path_answer_t ans);
    yields = 1'b0;
    ans    = NO_PATH;
    case (mode)
      dsp_pkg::MODE_CLEAR: begin
        // whole matrix, not only the nodes in use
        foreach (graph_weight[i, j]) graph_weight[i][j] = '0;
      end
      dsp_pkg::MODE_EDGE: begin
        graph_weight[a][b] = w;
        graph_weight[b][a] = w;
      end
      dsp_pkg::MODE_QUERY: begin
        yields = 1'b1;
        ans    = shortest_distance(a, b);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------------
  // Idle cycles after a request: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Endpoints stay inside the node count most of the time so that paths form.
  function automatic logic [dsp_pkg::NODE_BITS-1:0] pick_node(input int unsigned n_eff);
    if (n_eff == 0 || $urandom_range(0, 7) == 0) begin
      return (dsp_pkg::NODE_BITS)'($urandom_range(0, NODES - 1));
    end
    return (dsp_pkg::NODE_BITS)'($urandom_range(0, n_eff - 1));
  endfunction

  // Small weights make competing routes likely; zero removes an edge.
  function automatic logic [dsp_pkg::WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return (dsp_pkg::WEIGHT_BITS)'($urandom_range(1, 15));
      default: return (dsp_pkg::WEIGHT_BITS)'($urandom_range(1, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request and holds it until accepted. valid stays high into the
  // next request when no gap follows, so it is never dropped and raised in
  // the same step.
  task automatic send_request(input logic [dsp_pkg::MODE_BITS-1:0] mode,
                              input logic [dsp_pkg::NODE_BITS-1:0] a,
                              input logic [dsp_pkg::NODE_BITS-1:0] b,
                              input logic [dsp_pkg::WEIGHT_BITS-1:0] w,
                              input bit typed,
                              input path_answer_t typed_ans);
    bit           yields;
    path_answer_t ans;
    int           gap;
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.node_a      <= a;
    req_if.node_b      <= b;
    req_if.edge_weight <= w;
    do @(posedge clk); while (!req_if.ready);
    apply_request(mode, a, b, w, yields, ans);
    if (yields) answers_due.push_back(typed ? typed_ans : ans);
    case (mode)
      dsp_pkg::MODE_CLEAR: clears_sent++;
      dsp_pkg::MODE_EDGE:  edges_sent++;
      dsp_pkg::MODE_QUERY: queries_sent++;
      default:             unused_sent++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_answers();
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // node_count only changes while the block is idle: every answer is in and
  // a trailing clear has had time to finish.
  task automatic write_node_count(input logic [dsp_pkg::COUNT_BITS-1:0] value);
    req_if.valid <= 1'b0;
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    node_count_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycle_count, answers_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off per ticket that
  // the sender raises. The hold-off is timed here, not by the sender.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      sink_count   <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_tickets) begin
      res_if.ready <= 1'b0;
      holds_served <= holds_served + 1;
      sink_count   <= HOLD_CYCLES;
    end else if (sink_count != 0) begin
      sink_count <= sink_count - 1;
    end else if (steady) begin
      res_if.ready <= 1'b1;
    end else if (res_if.ready) begin
      res_if.ready <= 1'b0;
      sink_count   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
      sink_count   <= $urandom_range(0, 15);
    end
  end

  // Each accepted result is matched against the oldest outstanding answer.
  always @(posedge clk) begin : check_results
    path_answer_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (answers_due.size() == 0) begin
        $error("result with no answer due: path_found %0b, path_length %0d",
               res_if.path_found, res_if.path_length);
        mismatch_count++;
      end else begin
        want = answers_due.pop_front();
        answers_checked++;
        if (res_if.path_found !== want.found) begin
          $error("path_found: expected %0b, got %0b", want.found, res_if.path_found);
          mismatch_count++;
        end
        if (res_if.path_length !== want.length) begin
          $error("path_length: expected %0d, got %0d", want.length, res_if.path_length);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_eff;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_if.valid       = 1'b0;
    req_if.mode        = dsp_pkg::MODE_CLEAR;
    req_if.node_a      = '0;
    req_if.node_b      = '0;
    req_if.edge_weight = '0;
    res_if.ready       = 1'b0;
    node_count_cfg     = dsp_pkg::NODE_COUNT_RESET;
    foreach (graph_weight[i, j]) graph_weight[i][j] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The first request simply waits out the clearing pass that follows reset.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_NODE_COUNT) begin
        write_node_count(directed_plan[i].count);
      end else begin
        send_request(directed_plan[i].mode, directed_plan[i].a, directed_plan[i].b,
                     directed_plan[i].w, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    foreach (phase_plan[p]) begin
      write_node_count(phase_plan[p].count);
      steady <= phase_plan[p].steady;
      n_eff = (phase_plan[p].count > NODES) ? NODES : phase_plan[p].count;
      if (phase_plan[p].clear_first) begin
        send_request(dsp_pkg::MODE_CLEAR, pick_node(NODES), pick_node(NODES),
                     pick_weight(), 1'b0, NO_PATH);
      end
      // Build the graph, with the occasional dropped request mixed in.
      repeat (phase_plan[p].edges) begin
        if ($urandom_range(0, 15) == 0) begin
          send_request(MODE_UNUSED, pick_node(NODES), pick_node(NODES), pick_weight(),
                       1'b0, NO_PATH);
        end
        send_request(dsp_pkg::MODE_EDGE, pick_node(n_eff), pick_node(n_eff),
                     pick_weight(), 1'b0, NO_PATH);
      end
      // Burst phase: results are held off while queries keep coming, so the
      // output register and the engine both fill and request.ready drops.
      if (phase_plan[p].burst) hold_tickets <= hold_tickets + 1;
      repeat (phase_plan[p].queries) begin
        send_request(dsp_pkg::MODE_QUERY, pick_node(n_eff), pick_node(n_eff),
                     pick_weight(), 1'b0, NO_PATH);
      end
    end

    req_if.valid <= 1'b0;
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d queries, %0d edge writes, %0d clears, %0d unused mode",
             queries_sent + edges_sent + clears_sent + unused_sent, queries_sent,
             edges_sent, clears_sent, unused_sent);
    $display("Checked %0d answers across node counts 0 to 127, with a long result stall",
             answers_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
